// ----- src/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int IDX_W = 10;
	localparam int KEY_W = 32;
	localparam int CNT_W = 4;
	localparam int SUM_W = IDX_W + 2;
	localparam int DEFAULT_TABLE_DEPTH = 1024;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	localparam logic REG_WINDOW_FIRST = 1'b0;
	localparam logic REG_WINDOW_LAST  = 1'b1;

	localparam logic [IDX_W-1:0] WINDOW_FIRST_RESET = IDX_W'(0);
	localparam logic [IDX_W-1:0] WINDOW_LAST_RESET  = IDX_W'(1023);

	typedef struct packed {
		logic                    kind;
		logic [IDX_W-1:0]        entry_index;
		logic signed [KEY_W-1:0] key_value;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
		logic [CNT_W-1:0] probe_count;
	} result_t;

	typedef struct packed {
		logic                    is_search;
		logic [IDX_W-1:0]        index;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
	} window_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DONE
	} search_state_t;

endpackage

// ----- src/stbs_front.sv -----
// ----------------------------------------------------------------------------
// stbs_front
// Accepts input transactions, classifies them and drops writes past the table.
// ----------------------------------------------------------------------------
module stbs_front #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic           item_valid,
	output logic           item_stall,
	input  stbs_pkg::item_t item,
	output logic           push,
	input  logic           queue_full,
	output stbs_pkg::cmd_t  push_cmd
);
	import stbs_pkg::*;

	localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

	logic in_range;
	logic is_search;

	assign is_search  = (item.kind == KIND_SEARCH);
	assign in_range   = ({7'd0, item.entry_index} < DEPTH_W);
	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full && (is_search || in_range);

	assign push_cmd.is_search = is_search;
	assign push_cmd.index     = item.entry_index;
	assign push_cmd.key       = item.key_value;

endmodule

// ----- src/stbs_queue.sv -----
// ----------------------------------------------------------------------------
// stbs_queue
// Short command queue between the front and the search engine.
// ----------------------------------------------------------------------------
module stbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stbs_pkg::cmd_t  push_cmd,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop,
	output stbs_pkg::cmd_t  pop_cmd
);
	import stbs_pkg::*;

	cmd_t                   entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_pop;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_pop    = pop && pop_valid;
	assign pop_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- src/stbs_back.sv -----
// ----------------------------------------------------------------------------
// stbs_back
// Table memory and search engine: one memory probe per cycle, result register.
// ----------------------------------------------------------------------------
module stbs_back #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stbs_pkg::window_t  window,
	input  logic              cmd_valid,
	output logic              cmd_pop,
	input  stbs_pkg::cmd_t     cmd,
	output logic              result_valid,
	input  logic              result_stall,
	output stbs_pkg::result_t  result
);
	import stbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

	logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

	search_state_t state_q;
	search_state_t state_d;

	logic signed [SUM_W-1:0] lo_q;
	logic signed [SUM_W-1:0] hi_q;
	logic signed [SUM_W-1:0] lo_nx;
	logic signed [SUM_W-1:0] hi_nx;
	logic signed [SUM_W-1:0] mid_ext;
	logic signed [SUM_W-1:0] sum;
	logic [IDX_W-1:0]        mid_nx;
	logic [AW-1:0]           rd_addr;
	logic [IDX_W-1:0]        mid_s1;
	logic                    oob_s1;
	logic signed [KEY_W-1:0] rdata_s1;
	logic signed [KEY_W-1:0] probe_val;
	logic signed [KEY_W-1:0] key_q;
	logic                    eq;
	logic                    lt;
	logic                    go_on;
	logic                    found_q;
	logic [IDX_W-1:0]        pos_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    res_valid_q;
	result_t                 res_q;
	logic                    start;
	logic                    issue;
	logic                    load;
	logic                    hit;

	assign probe_val = oob_s1 ? '0 : rdata_s1;
	assign eq        = (probe_val == key_q);
	assign lt        = (probe_val < key_q);
	assign mid_ext   = {2'b00, mid_s1};

	always_comb begin
		if (state_q == ST_PROBE) begin
			lo_nx = lt ? (mid_ext + SUM_W'(1)) : lo_q;
			hi_nx = lt ? hi_q : (mid_ext - SUM_W'(1));
		end else begin
			lo_nx = {2'b00, window.first};
			hi_nx = {2'b00, window.last};
		end
	end

	assign sum     = lo_nx + hi_nx;
	assign mid_nx  = sum[IDX_W:1];
	assign rd_addr = AW'(mid_nx);
	assign go_on   = (lo_nx <= hi_nx);

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		start   = 1'b0;
		issue   = 1'b0;
		load    = 1'b0;
		hit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid && cmd.is_search) begin
					start   = 1'b1;
					issue   = go_on;
					state_d = go_on ? ST_PROBE : ST_DONE;
				end
			end
			ST_PROBE: begin
				if (eq) begin
					hit     = 1'b1;
					state_d = ST_DONE;
				end else if (go_on) begin
					issue = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || !result_stall) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && !cmd.is_search) begin
			mem[AW'(cmd.index)] <= cmd.key;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q   <= cmd.key;
			found_q <= 1'b0;
			pos_q   <= '0;
			cnt_q   <= go_on ? CNT_W'(1) : '0;
		end else if (hit) begin
			found_q <= 1'b1;
			pos_q   <= mid_s1;
		end else if (issue) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (issue) begin
			lo_q   <= lo_nx;
			hi_q   <= hi_nx;
			mid_s1 <= mid_nx;
			oob_s1 <= ({7'd0, mid_nx} >= DEPTH_W);
		end
		if (load) begin
			res_q.found       <= found_q;
			res_q.position    <= pos_q;
			res_q.probe_count <= cnt_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ----- src/sorted_table_binary_search_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted key table with binary search over a configurable index window.
// ----------------------------------------------------------------------------
// Write transactions store one signed key; keys must be written in ascending
// order and every probed entry written before a search reads it. A search
// transaction returns found, position and probe count over the window set in
// the window_first (0x0) and window_last (0x4) registers. Transactions pass
// through a two-entry queue into the search engine, which reads the table
// memory once per cycle: a write is stored as it leaves the queue, a search
// probes until a hit or an empty range, then waits for the result register.
// The result register lets the next transaction start while a result waits.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
	parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  stbs_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output stbs_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [stbs_pkg::PADDR_W-1:0]  paddr,
	input  logic [stbs_pkg::PDATA_W-1:0]  pwdata,
	output logic [stbs_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import stbs_pkg::*;

	window_t window_q;
	logic    push;
	logic    queue_full;
	cmd_t    push_cmd;
	logic    cmd_valid;
	logic    cmd_pop;
	cmd_t    cmd;
	logic    reg_write;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q.first <= WINDOW_FIRST_RESET;
			window_q.last  <= WINDOW_LAST_RESET;
		end else if (reg_write) begin
			unique case (paddr[2])
				REG_WINDOW_FIRST: window_q.first <= pwdata[IDX_W-1:0];
				REG_WINDOW_LAST:  window_q.last  <= pwdata[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_FIRST: prdata = PDATA_W'(window_q.first);
			REG_WINDOW_LAST:  prdata = PDATA_W'(window_q.last);
			default:          prdata = '0;
		endcase
	end

	stbs_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.queue_full (queue_full),
		.push_cmd   (push_cmd)
	);

	stbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop_valid (cmd_valid),
		.pop       (cmd_pop),
		.pop_cmd   (cmd)
	);

	stbs_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.window       (window_q),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- test/tb_sorted_table_binary_search_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_top
// Self-checking bench for the sorted table binary search block.
// ----------------------------------------------------------------------------
// Fills the table with ascending keys, laid out per phase, writing the entries
// that a coming search will probe, plus random writes. The search window is
// reprogrammed over APB between phases. Directed transactions from a short
// table come first, then random phases with random source gaps and sink stalls.
// Every search result is compared with a pinned outcome or a local prediction.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_top;

	import stbs_pkg::*;

	localparam int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH;
	localparam int ITEM_TARGET   = 1850;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 2000;
	localparam int REPORT_LIMIT  = 10;
	localparam int DIRECTED_ROWS = 19;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct {
		bit      fixed;
		result_t outcome;
	} pinned_t;

	typedef struct {
		logic [IDX_W-1:0]        first;
		logic [IDX_W-1:0]        last;
		logic                    kind;
		logic [IDX_W-1:0]        index;
		logic signed [KEY_W-1:0] key;
		bit                      fixed;
		result_t                 outcome;
	} directed_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// window as programmed, shared by the search prediction and the planner
	logic [IDX_W-1:0]        win_first = WINDOW_FIRST_RESET;
	logic [IDX_W-1:0]        win_last  = WINDOW_LAST_RESET;
	logic signed [KEY_W-1:0] lookup_keys [TABLE_DEPTH];
	logic signed [KEY_W-1:0] staged_keys [TABLE_DEPTH];
	bit                      staged_set  [TABLE_DEPTH];
	logic signed [KEY_W-1:0] phase_keys  [TABLE_DEPTH];

	result_t awaited_results [$];
	pinned_t pinned_outcomes [$];

	int items_sent = 0;
	int results_seen = 0;
	int bad_results = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit sender_burst = 1'b0;
	bit receiver_burst = 1'b0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{10'd0,    10'd1023, KIND_WRITE,  10'd511,  32'sd0,    1'b0, '0},
		'{10'd0,    10'd1023, KIND_SEARCH, 10'h2aa,  32'sd0,    1'b1, {1'b1, 10'd511, 4'd1}},
		'{10'd0,    10'd1023, KIND_WRITE,  10'd0,    KEY_MIN,   1'b0, '0},
		'{10'd0,    10'd1023, KIND_WRITE,  10'd1023, KEY_MAX,   1'b0, '0},
		'{10'd0,    10'd0,    KIND_SEARCH, 10'd1023, KEY_MIN,   1'b1, {1'b1, 10'd0, 4'd1}},
		'{10'd0,    10'd0,    KIND_SEARCH, 10'd0,    KEY_MAX,   1'b1, {1'b0, 10'd0, 4'd1}},
		'{10'd1023, 10'd1023, KIND_SEARCH, 10'h155,  KEY_MAX,   1'b1, {1'b1, 10'd1023, 4'd1}},
		'{10'd1023, 10'd1023, KIND_SEARCH, 10'h2aa,  KEY_MIN,   1'b1, {1'b0, 10'd0, 4'd1}},
		'{10'd1023, 10'd0,    KIND_SEARCH, 10'h3ff,  32'sd0,    1'b1, {1'b0, 10'd0, 4'd0}},
		'{10'd1023, 10'd0,    KIND_WRITE,  10'd1,    -32'sd5,   1'b0, '0},
		'{10'd0,    10'd1,    KIND_SEARCH, 10'd0,    -32'sd5,   1'b1, {1'b1, 10'd1, 4'd2}},
		'{10'd0,    10'd1,    KIND_SEARCH, 10'h155,  -32'sd4,   1'b0, '0},
		'{10'd0,    10'd1,    KIND_WRITE,  10'd0,    -32'sd100, 1'b0, '0},
		'{10'd0,    10'd1,    KIND_SEARCH, 10'h3ff,  -32'sd200, 1'b1, {1'b0, 10'd0, 4'd1}},
		'{10'd0,    10'd1,    KIND_WRITE,  10'd1022, 32'sd7,    1'b0, '0},
		'{10'd1022, 10'd1023, KIND_SEARCH, 10'd0,    KEY_MAX,   1'b1, {1'b1, 10'd1023, 4'd2}},
		'{10'd1022, 10'd1023, KIND_SEARCH, 10'h2aa,  32'sd8,    1'b1, {1'b0, 10'd0, 4'd2}},
		'{10'd1022, 10'd1023, KIND_SEARCH, 10'h155,  -32'sd1,   1'b1, {1'b0, 10'd0, 4'd1}},
		'{10'd1022, 10'd1023, KIND_SEARCH, 10'h3ff,  32'sd7,    1'b1, {1'b1, 10'd1022, 4'd1}}
	};

	sorted_table_binary_search_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic item_t pack_item(input logic kind, input logic [IDX_W-1:0] index,
			input logic signed [KEY_W-1:0] key);
		item_t txn;
		txn = {kind, index, key};
		return txn;
	endfunction

	function automatic result_t search_outcome(input logic signed [KEY_W-1:0] key);
		result_t                 r;
		int                      lo;
		int                      hi;
		int                      mid;
		logic signed [KEY_W-1:0] probe;
		r = '0;
		lo = int'(win_first);
		hi = int'(win_last);
		while (lo <= hi && !r.found) begin
			r.probe_count = r.probe_count + 1'b1;
			mid = (lo + hi) / 2;
			probe = (mid < TABLE_DEPTH) ? lookup_keys[mid] : '0;
			if (probe == key) begin
				r.found = 1'b1;
				r.position = IDX_W'(mid);
			end else if (probe < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return r;
	endfunction

	// first entry on the search path that still needs writing, or -1
	function automatic int first_unset_probe(input logic signed [KEY_W-1:0] key,
			input bit refresh);
		int lo;
		int hi;
		int mid;
		lo = int'(win_first);
		hi = int'(win_last);
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (!staged_set[mid] || (refresh && staged_keys[mid] != phase_keys[mid]))
				return mid;
			if (staged_keys[mid] == key)
				return -1;
			if (staged_keys[mid] < key)
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return -1;
	endfunction

	function automatic void build_layout();
		longint      acc;
		int unsigned stride_max;
		case ($urandom_range(0, 2))
			0: stride_max = 2;
			1: stride_max = 5000;
			default: stride_max = 32'h00ff_ffff;
		endcase
		acc = longint'(KEY_MIN);
		if ($urandom_range(0, 3) != 0)
			acc = acc + longint'($urandom_range(0, 32'h7fff_ffff));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (acc > longint'(KEY_MAX))
				acc = longint'(KEY_MAX);
			phase_keys[i] = acc[KEY_W-1:0];
			acc = acc + longint'($urandom_range(0, stride_max));
		end
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned             slot;
		logic signed [KEY_W-1:0] k;
		if (win_first > win_last)
			return $urandom;
		slot = $urandom_range(int'(win_first), int'(win_last));
		k = phase_keys[slot];
		case ($urandom_range(0, 7))
			4: k = k + ($urandom_range(0, 1) ? 1 : -1);
			5: k = $urandom;
			6: k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
			7: k = $urandom_range(0, 1) ? phase_keys[win_first] - 1 : phase_keys[win_last] + 1;
			default: ;
		endcase
		return k;
	endfunction

	task automatic send_item(input item_t txn, input bit fixed, input result_t outcome);
		int unsigned gap;
		pinned_t     pin;
		if (items_sent % 50 == 0)
			sender_burst = ($urandom_range(0, 3) == 0);
		gap = sender_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin.fixed = fixed;
		pin.outcome = outcome;
		pinned_outcomes.insert(pinned_outcomes.size(), pin);
		item_valid <= 1'b1;
		item <= txn;
		do @(posedge clk); while (item_stall);
		if (txn.kind == KIND_WRITE) begin
			staged_keys[txn.entry_index] = txn.key_value;
			staged_set[txn.entry_index] = 1'b1;
		end
		items_sent++;
	endtask

	task automatic apb_write(input logic reg_sel, input logic [IDX_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == REG_WINDOW_FIRST)
			win_first = value;
		else
			win_last = value;
	endtask

	task automatic set_window(input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_WINDOW_FIRST, first);
		apb_write(REG_WINDOW_LAST, last);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase();
		logic [IDX_W-1:0]        first;
		logic [IDX_W-1:0]        last;
		int unsigned             span;
		int                      searches;
		int                      slot;
		bit                      refresh;
		logic signed [KEY_W-1:0] key;
		case ($urandom_range(0, 9))
			0: begin
				first = '0;
				last = '1;
			end
			1: begin
				span = $urandom_range(1, 1023);
				first = IDX_W'(span);
				last = IDX_W'($urandom_range(0, span - 1));
			end
			2: begin
				first = IDX_W'($urandom_range(0, 1023));
				if ($urandom_range(0, 1))
					first = $urandom_range(0, 1) ? '0 : '1;
				last = first;
			end
			3: begin
				first = '0;
				last = IDX_W'($urandom_range(0, 40));
			end
			4: begin
				first = IDX_W'(1023 - $urandom_range(0, 40));
				last = '1;
			end
			default: begin
				first = IDX_W'($urandom_range(0, 1023));
				span = int'(first) + $urandom_range(0, 48);
				last = (span > 1023) ? '1 : IDX_W'(span);
			end
		endcase
		set_window(first, last);
		build_layout();
		searches = (first > last) ? 8 : $urandom_range(20, 60);
		repeat (searches) begin
			if (items_sent >= ITEM_TARGET)
				break;
			if ($urandom_range(0, 9) == 0)
				send_item(pack_item(KIND_WRITE, IDX_W'($urandom), $urandom), 1'b0, '0);
			key = pick_key();
			refresh = ($urandom_range(0, 7) != 0);
			for (slot = first_unset_probe(key, refresh); slot >= 0;
					slot = first_unset_probe(key, refresh))
				send_item(pack_item(KIND_WRITE, IDX_W'(slot), phase_keys[slot]), 1'b0, '0);
			send_item(pack_item(KIND_SEARCH, IDX_W'($urandom), key), 1'b0, '0);
		end
	endtask

	// predict on every accepted transaction
	always @(posedge clk) begin
		pinned_t pin;
		if (arst_n && item_valid && !item_stall) begin
			pin = pinned_outcomes.pop_front();
			if (item.kind == KIND_WRITE)
				lookup_keys[item.entry_index] = item.key_value;
			else
				awaited_results.insert(awaited_results.size(),
					pin.fixed ? pin.outcome : search_outcome(item.key_value));
		end
	end

	// check results and stall the result channel
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				bad_results++;
				if (bad_results <= REPORT_LIMIT)
					$display("%0t: unexpected result found=%0d position=%0d probes=%0d",
						$time, result.found, result.position, result.probe_count);
			end else begin
				want = awaited_results.pop_front();
				if (result.found !== want.found || result.position !== want.position ||
						result.probe_count !== want.probe_count) begin
					bad_results++;
					if (bad_results <= REPORT_LIMIT)
						$display("%0t: expected found=%0d position=%0d probes=%0d, got %0d %0d %0d",
							$time, want.found, want.position, want.probe_count,
							result.found, result.position, result.probe_count);
				end
			end
			results_seen++;
			if (results_seen % 40 == 0)
				receiver_burst = ($urandom_range(0, 3) == 0);
			stall_left = receiver_burst ? 0 : $urandom_range(0, 15);
		end
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			lookup_keys[i] = '0;
			staged_keys[i] = '0;
			staged_set[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[r]) begin
			if (directed_rows[r].first != win_first || directed_rows[r].last != win_last)
				set_window(directed_rows[r].first, directed_rows[r].last);
			send_item(pack_item(directed_rows[r].kind, directed_rows[r].index,
				directed_rows[r].key), directed_rows[r].fixed, directed_rows[r].outcome);
		end
		while (items_sent < ITEM_TARGET)
			run_phase();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			$display("%0d results never arrived", awaited_results.size());
		if (bad_results == 0 && awaited_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
